// ----- rtl/core/adaptive_compression_level_core_defines.svh -----
// assertion macros shared by the adaptive compression level core
`ifndef ADAPTIVE_COMPRESSION_LEVEL_CORE_DEFINES_SVH
`define ADAPTIVE_COMPRESSION_LEVEL_CORE_DEFINES_SVH

// same-cycle implication, checked on i_clk outside reset
`define ACL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("acl same-cycle check failed");

// next-cycle implication, checked on i_clk outside reset
`define ACL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("acl next-cycle check failed");

`endif

// ----- rtl/core/acl_pkg.sv -----
// types and constants of the adaptive compression level core
package acl_pkg;

    localparam int LEVEL_W = 4;
    localparam int PEND_W  = 40;
    localparam int SUM_W   = 48;
    localparam int RATE_W  = 20;
    localparam int PROD_W  = SUM_W + RATE_W;
    localparam int CFG_W   = 32;

    localparam logic [LEVEL_W-1:0] LEVEL_MIN   = 4'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 4'd14;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'd3;
    localparam logic [RATE_W-1:0]  RATE_SCALE  = 20'd1000000;
    localparam logic [CFG_W-1:0]   THRESH_RESET = 32'd100000;

    typedef enum logic [1:0] {
        CFG_FIXED_LEVEL      = 2'd0,
        CFG_INITIAL_LEVEL    = 2'd1,
        CFG_WINDOW_THRESHOLD = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] send_time;
        logic [24:0] send_bytes;
    } t_acl_in;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               window_closed;
        logic [SUM_W-1:0]   rate;
    } t_acl_out;

    function automatic logic [LEVEL_W-1:0] acl_clamp_level(input logic [LEVEL_W-1:0] v);
        logic [LEVEL_W-1:0] r;
        r = v;
        if (v < LEVEL_MIN) r = LEVEL_MIN;
        if (v > LEVEL_MAX) r = LEVEL_MAX;
        return r;
    endfunction

endpackage

// ----- rtl/core/adaptive_compression_level_core.sv -----
// adaptive compression level core: window accounting and bit-serial rate division
//
// Input channel i_in_valid / o_in_stall carries one item per sent chunk (send time,
// byte count). Output channel o_out_valid / i_out_stall returns exactly one item per
// input: current level, a window-closed flag and the latest rate.
// Config channel i_cfg_valid / o_cfg_ready writes fixed_level, initial_level and
// window_threshold; it is always ready and is meant to be used while the core is idle.
// One item at a time: o_in_stall is high from acceptance until the result is loaded
// into the output register. An item that closes no window (or arrives with the level
// frozen) goes straight to the output state. An item that closes a window passes
// through ring read and sum update, shift-add for the x1000000 scale, a saturation
// check, restoring division (one quotient bit per cycle), the level update and the
// output load. A saturated rate skips the division. The output register holds its
// item while i_out_stall is high; a finished result waits in the core until the
// register frees, and the next input is taken after that. Reset (synchronous, i_rst_n
// low) clears pending totals, sums, ring valid bits and last rate, loads level 3 and
// threshold 100000; the ring ram itself is not cleared.
module adaptive_compression_level_core import acl_pkg::*; #(
    parameter int RING_DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_acl_in          i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_acl_out         o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);
    localparam int SLOT_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int ENTRY_W = 2 * PEND_W;
    localparam int CNT_W   = 6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIVINIT,
        S_DIV,
        S_LEVEL,
        S_OUT
    } t_state;

    t_state                r_state;
    logic                  r_fixed;
    logic [CFG_W-1:0]      r_threshold;
    logic [PEND_W-1:0]     r_pend_t;
    logic [PEND_W-1:0]     r_pend_b;
    logic [SLOT_W-1:0]     r_slot;
    logic [RING_DEPTH-1:0] r_ring_valid;
    logic [SUM_W-1:0]      r_sum_t;
    logic [SUM_W-1:0]      r_sum_b;
    logic [SUM_W-1:0]      r_last_rate;
    logic [LEVEL_W-1:0]    r_level;
    logic [PROD_W-1:0]     r_acc;
    logic [SUM_W-1:0]      r_rem;
    logic [SUM_W-1:0]      r_quo;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_res_closed;
    logic                  r_out_valid;
    t_acl_out              r_out_data;

    logic                  in_accept;
    logic [PEND_W:0]       pend_t_sum;
    logic [PEND_W:0]       pend_b_sum;
    logic [PEND_W-1:0]     n_pend_t;
    logic [PEND_W-1:0]     n_pend_b;
    logic                  win_close;
    logic [SLOT_W-1:0]     n_slot;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [PEND_W-1:0]     old_t;
    logic [PEND_W-1:0]     old_b;
    logic [PROD_W-1:0]     n_acc;
    logic [RATE_W-1:0]     acc_hi;
    logic                  rate_sat;
    logic [SUM_W:0]        rem_sh;
    logic [SUM_W+1:0]      rem_diff;
    logic                  rem_borrow;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // saturating pending totals
    always_comb begin
        pend_t_sum = {1'b0, r_pend_t} + {9'b0, i_in_data.send_time};
        pend_b_sum = {1'b0, r_pend_b} + {16'b0, i_in_data.send_bytes};
        n_pend_t   = pend_t_sum[PEND_W] ? '1 : pend_t_sum[PEND_W-1:0];
        n_pend_b   = pend_b_sum[PEND_W] ? '1 : pend_b_sum[PEND_W-1:0];
        win_close  = n_pend_t > {8'b0, r_threshold};
        n_slot     = (r_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : r_slot + SLOT_W'(1);
    end

    // a ring entry never written reads as zero
    assign old_t = r_ring_valid[r_slot] ? ram_rdata[ENTRY_W-1:PEND_W] : '0;
    assign old_b = r_ring_valid[r_slot] ? ram_rdata[PEND_W-1:0] : '0;

    // msb-first shift-add over the scale constant
    assign n_acc = {r_acc[PROD_W-2:0], 1'b0}
                 + (RATE_SCALE[r_cnt[4:0]] ? {{RATE_W{1'b0}}, r_sum_t} : '0);

    // quotient above 48 bits iff the top part of the dividend reaches the divisor
    assign acc_hi   = r_acc[PROD_W-1:SUM_W];
    assign rate_sat = (r_sum_b == '0) || ({{(SUM_W-RATE_W){1'b0}}, acc_hi} >= r_sum_b);

    assign rem_sh     = {r_rem, r_quo[SUM_W-1]};
    assign rem_diff   = {1'b0, rem_sh} - {2'b0, r_sum_b};
    assign rem_borrow = rem_diff[SUM_W+1];

    acl_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (r_state == S_READ),
        .i_waddr(r_slot),
        .i_wdata({r_pend_t, r_pend_b}),
        .i_raddr(n_slot),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fixed      <= 1'b0;
            r_threshold  <= THRESH_RESET;
            r_pend_t     <= '0;
            r_pend_b     <= '0;
            r_slot       <= '0;
            r_ring_valid <= '0;
            r_sum_t      <= '0;
            r_sum_b      <= '0;
            r_last_rate  <= '0;
            r_level      <= LEVEL_RESET;
            r_cnt        <= '0;
            r_res_closed <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (r_fixed) begin
                            r_res_closed <= 1'b0;
                            r_state      <= S_OUT;
                        end else if (win_close) begin
                            r_pend_t <= n_pend_t;
                            r_pend_b <= n_pend_b;
                            r_slot   <= n_slot;
                            r_state  <= S_READ;
                        end else begin
                            r_pend_t     <= n_pend_t;
                            r_pend_b     <= n_pend_b;
                            r_res_closed <= 1'b0;
                            r_state      <= S_OUT;
                        end
                    end
                end
                S_READ: begin
                    // ram write of the new window happens in this cycle
                    r_sum_t <= r_sum_t + {8'b0, r_pend_t} - {8'b0, old_t};
                    r_sum_b <= r_sum_b + {8'b0, r_pend_b} - {8'b0, old_b};
                    r_ring_valid[r_slot] <= 1'b1;
                    r_pend_t <= '0;
                    r_pend_b <= '0;
                    r_acc    <= '0;
                    r_cnt    <= CNT_W'(RATE_W - 1);
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    r_acc <= n_acc;
                    if (r_cnt == '0) begin
                        r_state <= S_DIVINIT;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_DIVINIT: begin
                    if (rate_sat) begin
                        r_quo   <= '1;
                        r_state <= S_LEVEL;
                    end else begin
                        r_rem   <= {{(SUM_W-RATE_W){1'b0}}, acc_hi};
                        r_quo   <= r_acc[SUM_W-1:0];
                        r_cnt   <= CNT_W'(SUM_W - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= rem_borrow ? rem_sh[SUM_W-1:0] : rem_diff[SUM_W-1:0];
                    r_quo <= {r_quo[SUM_W-2:0], !rem_borrow};
                    if (r_cnt == '0) begin
                        r_state <= S_LEVEL;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_LEVEL: begin
                    if (r_quo < r_last_rate) begin
                        r_level <= (r_level >= LEVEL_MAX) ? LEVEL_MAX : r_level + LEVEL_W'(1);
                    end else begin
                        r_level <= (r_level <= LEVEL_MIN) ? LEVEL_MIN : r_level - LEVEL_W'(1);
                    end
                    r_last_rate  <= r_quo;
                    r_res_closed <= 1'b1;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid              <= 1'b1;
                        r_out_data.level         <= r_level;
                        r_out_data.window_closed <= r_res_closed;
                        r_out_data.rate          <= r_last_rate;
                        r_state                  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FIXED_LEVEL: begin
                        r_fixed <= i_cfg_data[0];
                    end
                    CFG_INITIAL_LEVEL: begin
                        r_level <= acl_clamp_level(i_cfg_data[LEVEL_W-1:0]);
                    end
                    CFG_WINDOW_THRESHOLD: begin
                        r_threshold <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

`include "adaptive_compression_level_core_defines.svh"

    `ACL_ASSERT_IMPL(a_level_range, 1'b1, (r_level >= LEVEL_MIN) && (r_level <= LEVEL_MAX))
    `ACL_ASSERT_IMPL(a_div_rem_below, r_state == S_DIV, r_rem < r_sum_b)
    `ACL_ASSERT_NEXT(a_frozen_no_window, in_accept && r_fixed, (r_state == S_OUT) && !r_res_closed)

endmodule

// ----- rtl/core/acl_ram.sv -----
// generic single-port-write ram with registered read
module acl_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- test/tb_top.sv -----
// testbench for the adaptive compression level core: directed and random chunks vs a predictor
module tb_top;
    import acl_pkg::*;

    localparam int RING_SLOTS = 8;
    localparam int POS_W = $clog2(RING_SLOTS);
    localparam logic [24:0] BYTES_MAX = 25'd16777216;
    localparam logic [1:0] CFG_SPARE_IDX = 2'd3;   // no register behind this index
    localparam logic [SUM_W-1:0] RATE_SAT = {SUM_W{1'b1}};
    localparam logic [PEND_W-1:0] PEND_SAT = {PEND_W{1'b1}};
    // a long run of full-size chunks with no time, kept open by the widest threshold
    localparam int LONG_CHUNKS = 40;
    localparam int LIMIT_CYCLES = 3000000;
    localparam int SETTLE_CYCLES = 100;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    t_acl_in          i_in_data = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_acl_out         o_out_data;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [1:0]       i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    adaptive_compression_level_core #(
        .RING_DEPTH(RING_SLOTS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic               cfg_frozen;
    logic [LEVEL_W-1:0] cfg_init_level;
    logic [CFG_W-1:0]   cfg_threshold;
    logic [PEND_W-1:0]  win_time;
    logic [PEND_W-1:0]  win_bytes;
    logic [POS_W-1:0]   ring_pos;
    logic [PEND_W-1:0]  hist_time [RING_SLOTS];
    logic [PEND_W-1:0]  hist_bytes [RING_SLOTS];
    logic [SUM_W-1:0]   hist_time_sum;
    logic [SUM_W-1:0]   hist_bytes_sum;
    logic [SUM_W-1:0]   prev_rate;
    logic [LEVEL_W-1:0] level_now;

    t_acl_out expected_levels [$];

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_len = 0;
    int held = 0;
    int items_sent = 0;
    int results_seen = 0;
    int windows_seen = 0;
    int reg_writes = 0;
    int mismatches = 0;
    int lowest_level = 15;
    int highest_level = 0;
    int cycles = 0;

    function automatic logic [LEVEL_W-1:0] bounded_level(input logic [LEVEL_W-1:0] v);
        if (v < LEVEL_MIN) return LEVEL_MIN;
        if (v > LEVEL_MAX) return LEVEL_MAX;
        return v;
    endfunction

    // floor(t * 1000000 / b) with saturation, done at full width
    function automatic logic [SUM_W-1:0] window_rate(input logic [SUM_W-1:0] t,
                                                     input logic [SUM_W-1:0] b);
        logic [127:0] q;
        if (b == '0) return RATE_SAT;
        q = ({80'd0, t} * 128'd1000000) / {80'd0, b};
        return (q > {80'd0, RATE_SAT}) ? RATE_SAT : q[SUM_W-1:0];
    endfunction

    function automatic void reset_model();
        cfg_frozen     = 1'b0;
        cfg_init_level = LEVEL_RESET;
        cfg_threshold  = THRESH_RESET;
        win_time       = '0;
        win_bytes      = '0;
        ring_pos       = '0;
        hist_time      = '{default: '0};
        hist_bytes     = '{default: '0};
        hist_time_sum  = '0;
        hist_bytes_sum = '0;
        prev_rate      = '0;
        level_now      = bounded_level(LEVEL_RESET);
    endfunction

    function automatic void predict_level(input t_acl_in c);
        t_acl_out           r;
        logic [PEND_W:0]    t_acc;
        logic [PEND_W:0]    b_acc;
        logic [SUM_W-1:0]   new_rate;
        r.window_closed = 1'b0;
        if (!cfg_frozen) begin
            t_acc = {1'b0, win_time} + {9'd0, c.send_time};
            b_acc = {1'b0, win_bytes} + {16'd0, c.send_bytes};
            win_time  = t_acc[PEND_W] ? PEND_SAT : t_acc[PEND_W-1:0];
            win_bytes = b_acc[PEND_W] ? PEND_SAT : b_acc[PEND_W-1:0];
            if (win_time > {8'd0, cfg_threshold}) begin
                // slot moves first, so the first window lands in slot 1
                ring_pos = (ring_pos == POS_W'(RING_SLOTS - 1)) ? '0 : ring_pos + POS_W'(1);
                hist_time_sum  = hist_time_sum + {8'd0, win_time}
                               - {8'd0, hist_time[ring_pos]};
                hist_bytes_sum = hist_bytes_sum + {8'd0, win_bytes}
                               - {8'd0, hist_bytes[ring_pos]};
                hist_time[ring_pos]  = win_time;
                hist_bytes[ring_pos] = win_bytes;
                win_time  = '0;
                win_bytes = '0;
                new_rate = window_rate(hist_time_sum, hist_bytes_sum);
                if (new_rate < prev_rate)
                    level_now = (level_now >= LEVEL_MAX) ? LEVEL_MAX
                                                         : level_now + LEVEL_W'(1);
                else
                    level_now = (level_now <= LEVEL_MIN) ? LEVEL_MIN
                                                         : level_now - LEVEL_W'(1);
                prev_rate = new_rate;
                r.window_closed = 1'b1;
            end
        end
        r.level = level_now;
        r.rate  = prev_rate;
        expected_levels.push_back(r);
    endfunction

    // register writes, result checks and predictions, all sampled at the edge
    always @(posedge i_clk) begin : monitor
        t_acl_out want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                reg_writes++;
                case (i_cfg_index)
                    CFG_FIXED_LEVEL: cfg_frozen = i_cfg_data[0];
                    CFG_INITIAL_LEVEL: begin
                        cfg_init_level = i_cfg_data[LEVEL_W-1:0];
                        level_now = bounded_level(cfg_init_level);
                    end
                    CFG_WINDOW_THRESHOLD: cfg_threshold = i_cfg_data;
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (o_out_data.window_closed === 1'b1) windows_seen++;
                if (int'(o_out_data.level) < lowest_level) lowest_level = int'(o_out_data.level);
                if (int'(o_out_data.level) > highest_level)
                    highest_level = int'(o_out_data.level);
                if (expected_levels.size() == 0) begin
                    $error("result with no item outstanding: level %0d closed %0d rate %0d",
                           o_out_data.level, o_out_data.window_closed, o_out_data.rate);
                    mismatches++;
                end else begin
                    want = expected_levels.pop_front();
                    if (o_out_data.level !== want.level) begin
                        $error("level: expected %0d, got %0d", want.level, o_out_data.level);
                        mismatches++;
                    end
                    if (o_out_data.window_closed !== want.window_closed) begin
                        $error("window_closed: expected %0d, got %0d",
                               want.window_closed, o_out_data.window_closed);
                        mismatches++;
                    end
                    if (o_out_data.rate !== want.rate) begin
                        $error("rate: expected %0d, got %0d", want.rate, o_out_data.rate);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) predict_level(i_in_data);
        end
    end

    // receiver: long hold-offs first, random stalls otherwise
    always @(posedge i_clk) begin
        if (held < hold_len) begin
            i_out_stall <= 1'b1;
            held <= held + 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_chunk(input logic [31:0] t, input logic [24:0] n);
        i_in_valid <= 1'b1;
        i_in_data  <= '{send_time: t, send_bytes: n};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (results_seen != items_sent) @(posedge i_clk);
    endtask

    // writes all three registers plus the unused index, upper data bits are junk
    task automatic program_regs(input logic frozen, input logic [LEVEL_W-1:0] init_lvl,
                                input logic [CFG_W-1:0] thresh);
        logic [1:0]       reg_idx [4];
        logic [CFG_W-1:0] reg_val [4];
        logic [CFG_W-1:0] junk;
        junk = $urandom;
        reg_idx[0] = CFG_FIXED_LEVEL;
        reg_idx[1] = CFG_INITIAL_LEVEL;
        reg_idx[2] = CFG_WINDOW_THRESHOLD;
        reg_idx[3] = CFG_SPARE_IDX;
        reg_val[0] = {junk[CFG_W-1:1], frozen};
        reg_val[1] = {junk[CFG_W-1:LEVEL_W], init_lvl};
        reg_val[2] = thresh;
        reg_val[3] = $urandom;
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_idx[k];
            i_cfg_data  <= reg_val[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // mostly a handful of chunks per window, now and then a full-range time
    function automatic logic [31:0] rand_time(input logic [31:0] thresh);
        case ($urandom_range(9))
            0: return 32'd0;
            1, 2: return $urandom;
            default: return $urandom_range(thresh / 3 + 2);
        endcase
    endfunction

    function automatic logic [24:0] rand_bytes();
        case ($urandom_range(9))
            0: return 25'd0;
            1: return BYTES_MAX;
            2, 3, 4: return 25'($urandom_range(BYTES_MAX));
            default: return 25'($urandom_range(8192, 64));
        endcase
    endfunction

    task automatic test_window_edges();
        send_chunk(32'd0, 25'd0);
        send_chunk(32'd100000, 25'd0);          // equal to threshold, stays open
        send_chunk(32'd1, 25'd0);               // closes with no bytes at all
        send_chunk(32'hFFFF_FFFF, 25'd1);       // quotient far beyond 48 bits
        send_chunk(32'd0, 25'd16777215);
        send_chunk(32'd200000, BYTES_MAX);
        send_chunk(32'hFFFF_FFFF, BYTES_MAX);
        wait_idle();
    endtask

    task automatic test_level_limits();
        program_regs(1'b0, 4'd15, 32'd0);       // loads as the top level
        send_chunk(32'd0, 25'd5);
        send_chunk(32'd1, BYTES_MAX);
        send_chunk(32'd1, BYTES_MAX);
        send_chunk(32'd2, 25'd1);
        wait_idle();
        program_regs(1'b0, 4'd0, 32'hFFFF_FFFF);  // loads as the bottom level
        send_chunk(32'hFFFF_FFFF, 25'd1000);
        send_chunk(32'd1, 25'd0);
        send_chunk(32'hFFFF_FFFF, 25'd0);
        send_chunk(32'd5, BYTES_MAX);
        wait_idle();
    endtask

    task automatic test_frozen_level();
        program_regs(1'b1, 4'd7, 32'd0);
        send_chunk(32'hFFFF_FFFF, BYTES_MAX);
        send_chunk(32'd1, 25'd1);
        send_chunk(32'd0, 25'd0);
        wait_idle();
        program_regs(1'b0, LEVEL_RESET, THRESH_RESET);
    endtask

    task automatic test_long_window();
        program_regs(1'b0, LEVEL_RESET, 32'hFFFF_FFFF);
        repeat (LONG_CHUNKS) send_chunk(32'd0, BYTES_MAX);
        send_chunk(32'hFFFF_FFFF, 25'd1);
        send_chunk(32'd1, 25'd0);
        wait_idle();
    endtask

    task automatic test_output_hold();
        idle_pct = 0;
        stall_pct = 0;
        program_regs(1'b0, 4'd8, 32'd20000);
        hold_len = hold_len + 400;
        repeat (24) send_chunk(rand_time(cfg_threshold), rand_bytes());
        wait_idle();
    endtask

    task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                       input int n_chunks);
        int          done_chunks;
        int          batch;
        logic        frozen;
        logic [31:0] thresh;
        idle_pct = sender_idle;
        stall_pct = receiver_stall;
        done_chunks = 0;
        while (done_chunks < n_chunks) begin
            frozen = ($urandom_range(7) == 0);
            case ($urandom_range(4))
                0: thresh = '0;
                1: thresh = $urandom_range(5000);
                2: thresh = THRESH_RESET;
                3: thresh = $urandom;
                default: thresh = '1;
            endcase
            wait_idle();
            program_regs(frozen, 4'($urandom_range(15)), thresh);
            batch = frozen ? 10 : $urandom_range(110, 60);
            repeat (batch) send_chunk(rand_time(thresh), rand_bytes());
            // frozen batches close no window in the block and are not counted
            if (!frozen) done_chunks += batch;
        end
        wait_idle();
    endtask

    initial begin
        reset_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_window_edges();
        test_level_limits();
        test_frozen_level();
        test_long_window();
        test_output_hold();
        test_random_traffic(0, 0, 200);
        test_random_traffic(77, 0, 200);
        test_random_traffic(0, 77, 200);
        test_random_traffic(7, 7, 200);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_levels.size() != 0) begin
            $error("%0d expected results never arrived", expected_levels.size());
            mismatches++;
        end
        $display("covered %0d chunks, %0d results compared, %0d of them closed a window",
                 items_sent, results_seen, windows_seen);
        $display("%0d register writes, output level ranged %0d..%0d, %0d mismatches",
                 reg_writes, lowest_level, highest_level, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
